// ===== rtl/rra_pkg.sv =====
// Shared constants and operation codes for the register rename allocator.
// No dependencies; used by register_rename_allocator_unit.
`default_nettype none
package rra_pkg;
   localparam int PHYS_REGS_DEF = 128;
   localparam int ARCH_REGS_DEF = 256;
   localparam logic [7:0] FREED_ARCH_INDEX = 8'd255;

   typedef enum logic [2:0] {
      OP_RENAME_DEST = 3'd0,
      OP_RENAME_SRC  = 3'd1,
      OP_COMPLETE    = 3'd2,
      OP_RETIRE      = 3'd3,
      OP_RECOVER     = 3'd4,
      OP_QUERY       = 3'd5,
      OP_LOOKUP      = 3'd6,
      OP_NOP         = 3'd7
   } op_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/rra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/register_rename_allocator_unit.sv =====
// Register renamer: FIFO free list, speculative and committed maps.
// Depends on rra_pkg and rra_ram.
//
// Usage: drive req_* and raise start while busy is low; the operation is
// taken at that edge and busy rises. Every operation gives exactly one
// result: rsp_valid pulses for one cycle with rsp_* once the operation
// has passed ST_READ, ST_RESOLVE and ST_WRITE, and busy falls in that
// same cycle, so a new operation may be started then.
// The working states are set by the memories: ST_READ issues reads of
// the free list, the maps and the arch index table; ST_RESOLVE uses the
// arch index to read the committed map (retire) and reads the producer
// table; ST_WRITE modifies and writes everything back.
// Recover goes through the same states: the presence bits copy at once and a
// per-entry select bit makes the speculative map read through the
// committed map until that entry is next written.
// Reset (synchronous) empties both maps and makes all physical registers
// free in order; no clearing pass is needed. The receiver cannot stall.
`default_nettype none
module register_rename_allocator_unit #(
   parameter int PHYS_REGS = rra_pkg::PHYS_REGS_DEF,
   parameter int ARCH_REGS = rra_pkg::ARCH_REGS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [7:0]  req_arch_reg,
   input  wire logic [6:0]  req_phys_reg,
   input  wire logic [63:0] req_producer_id,
   output logic             rsp_valid,
   output logic [6:0]       rsp_phys_out,
   output logic             rsp_mapped,
   output logic             rsp_phys_ready,
   output logic [63:0]      rsp_producer_out,
   output logic [7:0]       rsp_free_count,
   output logic [1:0]       rsp_status
);
   localparam int PW = $clog2(PHYS_REGS);
   localparam int AW = $clog2(ARCH_REGS);
   localparam int TW = $clog2(PHYS_REGS + 1);

   localparam logic [2:0] OP_LOOKUP_C = rra_pkg::OP_LOOKUP;
   localparam logic [2:0] OP_SRC_C    = rra_pkg::OP_RENAME_SRC;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RESOLVE, ST_WRITE} state_type;

   state_type state_ff;
   logic [2:0]  op_ff;
   logic [7:0]  arch_ff;
   logic [6:0]  phys_ff;
   logic [63:0] pid_ff;
   logic [PW-1:0] pop_ff, spec_ff, rep_idx_ff;
   logic [7:0]  a_ff;

   logic [PW-1:0] head_ff, tail_ff, head_in, tail_in;
   logic [TW-1:0] total_ff, total_in;

   logic [PHYS_REGS-1:0] valid_ff, pw_wr_ff, fifo_wr_ff;
   logic [ARCH_REGS-1:0] spec_pres_ff, commit_pres_ff, sel_ff;

   logic          rsp_valid_ff, rsp_mapped_ff, rsp_ready_ff;
   logic [6:0]    rsp_phys_ff;
   logic [63:0]   rsp_prod_ff;
   logic [7:0]    rsp_free_ff;
   logic [1:0]    rsp_status_ff;

   // RAM ports
   logic [PW-1:0] fifo_rd, spec_rd, commit_rd;
   logic [7:0]    arch_rd;
   logic [63:0]   prod_rd;
   logic          fifo_we, spec_we, commit_we, ai_we, prod_we;
   logic [PW-1:0] fifo_wdata, spec_wdata, commit_wdata, ai_waddr, prod_waddr;
   logic [AW-1:0] spec_waddr, commit_waddr, commit_raddr;
   logic [7:0]    ai_wdata;
   logic [63:0]   prod_wdata;
   logic [PW-1:0] prod_raddr;

   logic [PW-1:0] phys_idx;
   logic [AW-1:0] arch_idx, a_idx;
   logic          phys_ok, arch_ok, a_ok;
   logic [PW-1:0] spec_res;
   logic [7:0]    a_res;

   assign phys_idx = PW'(phys_ff);
   assign arch_idx = AW'(arch_ff);
   assign a_idx    = AW'(a_ff);
   assign phys_ok  = 32'(phys_ff) < PHYS_REGS;
   assign arch_ok  = 32'(arch_ff) < ARCH_REGS;
   assign a_ok     = 32'(a_ff) < ARCH_REGS;
   assign spec_res = sel_ff[arch_idx] ? commit_rd : spec_rd;
   assign a_res    = pw_wr_ff[phys_idx] ? arch_rd : 8'd0;

   assign commit_raddr = (state_ff == ST_RESOLVE) ? AW'(a_res) : arch_idx;
   assign prod_raddr   = (op_ff == OP_LOOKUP_C || op_ff == OP_SRC_C) ? spec_res : phys_idx;

   rra_ram #(.WIDTH(PW), .DEPTH(PHYS_REGS)) u_fifo (
      .clock, .we(fifo_we), .waddr(tail_ff), .wdata(fifo_wdata),
      .raddr(head_ff), .rdata(fifo_rd));
   rra_ram #(.WIDTH(PW), .DEPTH(ARCH_REGS)) u_spec (
      .clock, .we(spec_we), .waddr(spec_waddr), .wdata(spec_wdata),
      .raddr(arch_idx), .rdata(spec_rd));
   rra_ram #(.WIDTH(PW), .DEPTH(ARCH_REGS)) u_commit (
      .clock, .we(commit_we), .waddr(commit_waddr), .wdata(commit_wdata),
      .raddr(commit_raddr), .rdata(commit_rd));
   rra_ram #(.WIDTH(8), .DEPTH(PHYS_REGS)) u_arch_idx (
      .clock, .we(ai_we), .waddr(ai_waddr), .wdata(ai_wdata),
      .raddr(phys_idx), .rdata(arch_rd));
   rra_ram #(.WIDTH(64), .DEPTH(PHYS_REGS)) u_prod (
      .clock, .we(prod_we), .waddr(prod_waddr), .wdata(prod_wdata),
      .raddr(prod_raddr), .rdata(prod_rd));

   // Write-back cycle decisions
   logic          empty, full;
   logic [63:0]   prod_res;
   logic          had;
   logic [PW-1:0] old;
   logic          do_pop, do_rel, do_push;
   logic [PW-1:0] rel_idx;
   logic          valid_set, spec_set, commit_set, sel_clr;
   logic [6:0]    o_phys;
   logic          o_mapped, o_ready;
   logic [63:0]   o_prod;
   logic [1:0]    o_status;

   assign empty    = (total_ff == '0);
   assign full     = (32'(total_ff) >= PHYS_REGS);
   assign prod_res = pw_wr_ff[rep_idx_ff] ? prod_rd : 64'd0;
   assign had      = commit_pres_ff[a_idx];
   assign old      = commit_rd;

   always_comb begin
      do_pop = 1'b0; do_rel = 1'b0; do_push = 1'b0; rel_idx = old;
      valid_set = 1'b0; spec_set = 1'b0; commit_set = 1'b0; sel_clr = 1'b0;
      fifo_we = 1'b0; fifo_wdata = old;
      spec_we = 1'b0; spec_waddr = arch_idx; spec_wdata = pop_ff;
      commit_we = 1'b0; commit_waddr = arch_idx; commit_wdata = pop_ff;
      ai_we = 1'b0; ai_waddr = pop_ff; ai_wdata = arch_ff;
      prod_we = 1'b0; prod_waddr = pop_ff; prod_wdata = pid_ff;
      o_phys = 7'd0; o_mapped = 1'b0; o_ready = 1'b0; o_prod = 64'd0;
      o_status = rra_pkg::STATUS_OK;
      if (state_ff == ST_WRITE) begin
         unique case (op_ff)
            rra_pkg::OP_RENAME_DEST: begin
               if (arch_ok) begin
                  if (empty) begin
                     o_status = rra_pkg::STATUS_EMPTY;
                  end else begin
                     do_pop = 1'b1; spec_we = 1'b1; spec_set = 1'b1; sel_clr = 1'b1;
                     ai_we = 1'b1; prod_we = 1'b1;
                     o_phys = 7'(pop_ff); o_prod = pid_ff;
                  end
               end
            end
            rra_pkg::OP_RENAME_SRC: begin
               if (arch_ok) begin
                  if (spec_pres_ff[arch_idx]) begin
                     o_phys = 7'(spec_ff); o_mapped = 1'b1;
                     o_ready = valid_ff[rep_idx_ff]; o_prod = prod_res;
                  end else if (empty) begin
                     o_status = rra_pkg::STATUS_EMPTY;
                  end else begin
                     do_pop = 1'b1; spec_we = 1'b1; spec_set = 1'b1; sel_clr = 1'b1;
                     commit_we = 1'b1; commit_set = 1'b1;
                     ai_we = 1'b1; prod_we = 1'b1; prod_wdata = 64'd0;
                     o_phys = 7'(pop_ff); o_ready = 1'b1;
                  end
               end
            end
            rra_pkg::OP_COMPLETE: begin
               o_phys = phys_ff;
               if (phys_ok) begin
                  valid_set = 1'b1; o_ready = 1'b1; o_prod = prod_res;
               end
            end
            rra_pkg::OP_RETIRE: begin
               o_phys = phys_ff;
               if (phys_ok) begin
                  o_ready = valid_ff[rep_idx_ff]; o_prod = prod_res;
                  if (a_ok) begin
                     commit_we = 1'b1; commit_waddr = a_idx; commit_wdata = phys_idx;
                     commit_set = 1'b1;
                     // keep the speculative view of this entry before the commit changes
                     if (sel_ff[a_idx]) begin
                        spec_we = 1'b1; spec_waddr = a_idx; spec_wdata = old;
                        sel_clr = 1'b1;
                     end
                     if (had) begin
                        do_rel = 1'b1;
                        ai_we = 1'b1; ai_waddr = old; ai_wdata = rra_pkg::FREED_ARCH_INDEX;
                        prod_we = 1'b1; prod_waddr = old; prod_wdata = 64'd0;
                        if (full) begin
                           o_status = rra_pkg::STATUS_OVERFLOW;
                        end else begin
                           do_push = 1'b1; fifo_we = 1'b1;
                        end
                        if (old == phys_idx) begin
                           o_ready = 1'b0; o_prod = 64'd0;
                        end
                     end
                  end
               end
            end
            rra_pkg::OP_QUERY: begin
               o_phys = phys_ff;
               if (phys_ok) begin
                  o_ready = valid_ff[rep_idx_ff]; o_prod = prod_res;
               end
            end
            rra_pkg::OP_LOOKUP: begin
               if (arch_ok && spec_pres_ff[arch_idx]) begin
                  o_phys = 7'(spec_ff); o_mapped = 1'b1;
                  o_ready = valid_ff[rep_idx_ff]; o_prod = prod_res;
               end
            end
            rra_pkg::OP_RECOVER, rra_pkg::OP_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      total_in = total_ff;
      if (do_pop) begin
         head_in  = (head_ff == PW'(PHYS_REGS - 1)) ? '0 : head_ff + 1'b1;
         total_in = total_ff - 1'b1;
      end
      if (do_push) begin
         tail_in  = (tail_ff == PW'(PHYS_REGS - 1)) ? '0 : tail_ff + 1'b1;
         total_in = total_ff + 1'b1;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phys_out     = rsp_phys_ff;
   assign rsp_mapped       = rsp_mapped_ff;
   assign rsp_phys_ready   = rsp_ready_ff;
   assign rsp_producer_out = rsp_prod_ff;
   assign rsp_free_count   = rsp_free_ff;
   assign rsp_status       = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         total_ff       <= TW'(PHYS_REGS);
         valid_ff       <= '0;
         pw_wr_ff       <= '0;
         fifo_wr_ff     <= '0;
         spec_pres_ff   <= '0;
         commit_pres_ff <= '0;
         sel_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_WRITE);
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= req_operation;
                  arch_ff  <= req_arch_reg;
                  phys_ff  <= req_phys_reg;
                  pid_ff   <= req_producer_id;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_RESOLVE;
            end
            ST_RESOLVE: begin
               // read the free-list slot as its reset value until first written
               pop_ff     <= fifo_wr_ff[head_ff] ? fifo_rd : head_ff;
               spec_ff    <= spec_res;
               a_ff       <= a_res;
               rep_idx_ff <= prod_raddr;
               state_ff   <= ST_WRITE;
            end
            ST_WRITE: begin
               head_ff  <= head_in;
               tail_ff  <= tail_in;
               total_ff <= total_in;
               if (fifo_we) begin
                  fifo_wr_ff[tail_ff] <= 1'b1;
               end
               if (ai_we) begin
                  pw_wr_ff[ai_waddr] <= 1'b1;
               end
               if (do_pop) begin
                  valid_ff[pop_ff] <= (op_ff == OP_SRC_C);
               end
               if (valid_set) begin
                  valid_ff[phys_idx] <= 1'b1;
               end
               if (do_rel) begin
                  valid_ff[rel_idx] <= 1'b0;
               end
               if (spec_set) begin
                  spec_pres_ff[arch_idx] <= 1'b1;
               end
               if (sel_clr) begin
                  sel_ff[spec_waddr] <= 1'b0;
               end
               if (commit_set) begin
                  commit_pres_ff[commit_waddr] <= 1'b1;
               end
               if (op_ff == 3'(rra_pkg::OP_RECOVER)) begin
                  spec_pres_ff <= commit_pres_ff;
                  sel_ff       <= '1;
               end
               rsp_phys_ff   <= o_phys;
               rsp_mapped_ff <= o_mapped;
               rsp_ready_ff  <= o_ready;
               rsp_prod_ff   <= o_prod;
               rsp_free_ff   <= 8'(total_in);
               rsp_status_ff <= o_status;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
